// ----- src/bbd_pkg.sv -----
// bbd_pkg: shared widths, register indexes and pipeline codes for the bilinear demosaic
// no dependencies; used by bayer_bilinear_demosaic_top

package bbd_pkg;

    // fixed field widths
    localparam int PIX_W      = 12;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int FW_W       = 13;
    localparam int FH_W       = 14;
    localparam int PAT_W      = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAYER_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 2'd3;

    // reset values
    localparam int RST_FRAME_WIDTH  = 1920;
    localparam int RST_FRAME_HEIGHT = 1080;
    localparam int HEIGHT_LIMIT     = 8192;
    localparam logic [PAT_W-1:0] RST_PATTERN   = 2'd0;
    localparam logic [PIX_W-1:0] RST_MAX_VALUE = 12'd4095;

    // where the result of a request comes from
    typedef enum logic [2:0] {
        RES_NONE,
        RES_TAIL,
        RES_UPPER,
        RES_MIDDLE,
        RES_CENTRE,
        RES_INTERIOR
    } res_kind_t;

    // colour role of an interior site
    typedef enum logic [1:0] {
        SITE_RED,
        SITE_BLUE,
        SITE_GREEN_RROW,
        SITE_GREEN_BROW
    } site_t;

endpackage

// ----- src/bayer_bilinear_demosaic_top.sv -----
// bayer_bilinear_demosaic_top: streaming 3x3 bilinear Bayer demosaic with two line memories
// depends on bbd_pkg for widths, register indexes and pipeline codes

// Takes one raw Bayer request per clock and returns one BGR pixel per raster position, one
// line plus one pixel behind the input; the last line plus one pixel of a frame leave on
// blanking requests (s_func = 1). Throughput is one request per clock unless the output
// stalls, set by the line memories' one read and one write-back per request; requests pass
// the stage 1 and output registers. The line memories need no clearing pass after reset, so
// requests are taken from the first clock out of reset. Write configuration via cfg_* only
// while the stream is idle, which the block does not enforce; width and height are clamped
// to 3..MAX_WIDTH and 3..8192, and max_value clips interpolated interior pixels only.

module bayer_bilinear_demosaic_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // raw pixel requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [bbd_pkg::PIX_W-1:0]     s_raw_pixel,
    // demosaiced pixels
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bbd_pkg::PIX_W-1:0]     m_blue,
    output logic [bbd_pkg::PIX_W-1:0]     m_green,
    output logic [bbd_pkg::PIX_W-1:0]     m_red,
    output logic                          m_end_of_line,
    output logic                          m_end_of_frame,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = bbd_pkg::PIX_W;
    localparam int RW = bbd_pkg::ROW_W;
    localparam int RST_W_LAST = (bbd_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                                (MAX_WIDTH - 1) : (bbd_pkg::RST_FRAME_WIDTH - 1);
    localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);

    function automatic logic [PW-1:0] clip_px(input logic [PW-1:0] v, input logic [PW-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // configuration registers, width and height kept as clamped last indexes
    logic [CW-1:0]                w_last_reg, w_last_next;
    logic [RW-1:0]                h_last_reg, h_last_next;
    logic [bbd_pkg::PAT_W-1:0]    pattern_reg;
    logic [PW-1:0]                max_value_reg;
    logic [15:0]                  fw16;
    logic [bbd_pkg::FH_W-1:0]     fh14;

    assign cfg_ready = 1'b1;

    // clamp incoming width and height
    always_comb begin
        fw16 = 16'(cfg_data[bbd_pkg::FW_W-1:0]);
        fh14 = cfg_data[bbd_pkg::FH_W-1:0];
        if (fw16 < 16'd3) begin
            w_last_next = CW'(2);
        end else if (fw16 > MAXW16) begin
            w_last_next = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_next = CW'(fw16 - 16'd1);
        end
        if (fh14 < 14'd3) begin
            h_last_next = RW'(2);
        end else if (fh14 > 14'(bbd_pkg::HEIGHT_LIMIT)) begin
            h_last_next = RW'(bbd_pkg::HEIGHT_LIMIT - 1);
        end else begin
            h_last_next = RW'(fh14 - 14'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg    <= CW'(RST_W_LAST);
            h_last_reg    <= RW'(bbd_pkg::RST_FRAME_HEIGHT - 1);
            pattern_reg   <= bbd_pkg::RST_PATTERN;
            max_value_reg <= bbd_pkg::RST_MAX_VALUE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bbd_pkg::CFG_FRAME_WIDTH:   w_last_reg    <= w_last_next;
                bbd_pkg::CFG_FRAME_HEIGHT:  h_last_reg    <= h_last_next;
                bbd_pkg::CFG_BAYER_PATTERN: pattern_reg   <= cfg_data[bbd_pkg::PAT_W-1:0];
                bbd_pkg::CFG_MAX_VALUE:     max_value_reg <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic s_accept;
    logic s1_valid_reg, s1_fire, mem_we;
    logic s1_pixel_reg;
    logic out_valid_reg;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;
    assign mem_we   = s1_fire && s1_pixel_reg;

    // position counters
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;

    // stage 0 decode
    bbd_pkg::res_kind_t kind0;
    bbd_pkg::site_t     site0;
    logic [RW-1:0]      orow0;
    logic [CW-1:0]      ocol0;
    logic [CW-1:0]      rd_addr;
    logic               emit0, eol0, eof0;

    // work out which result a request gives and move the counters
    always_comb begin
        kind0        = bbd_pkg::RES_NONE;
        emit0        = 1'b0;
        orow0        = out_row_reg;
        ocol0        = out_col_reg;
        rd_addr      = in_col_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (s_func) begin
            // blanking drains the tail of the frame
            rd_addr = out_col_reg;
            if (in_row_reg == '0 && in_col_reg == '0 &&
                (out_row_reg != '0 || out_col_reg != '0)) begin
                emit0 = 1'b1;
                kind0 = (out_row_reg >= h_last_reg) ? bbd_pkg::RES_MIDDLE : bbd_pkg::RES_UPPER;
            end
        end else begin
            if (in_col_reg == '0 && in_row_reg >= RW'(2)) begin
                // last pixel of the line two above
                emit0 = 1'b1;
                kind0 = bbd_pkg::RES_TAIL;
                orow0 = in_row_reg - RW'(2);
                ocol0 = w_last_reg;
            end
            if (in_col_reg != '0 && in_row_reg != '0) begin
                emit0 = 1'b1;
                orow0 = in_row_reg - RW'(1);
                ocol0 = in_col_reg - CW'(1);
                if (ocol0 == '0 || ocol0 >= w_last_reg || orow0 == '0 ||
                    orow0 >= h_last_reg) begin
                    kind0 = bbd_pkg::RES_CENTRE;
                end else begin
                    kind0 = bbd_pkg::RES_INTERIOR;
                end
            end
            if (in_col_reg >= w_last_reg) begin
                in_col_next = '0;
                in_row_next = (in_row_reg >= h_last_reg) ? '0 : in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        // output position follows the emitted pixel
        if (emit0) begin
            if (ocol0 >= w_last_reg) begin
                out_col_next = '0;
                out_row_next = (orow0 >= h_last_reg) ? '0 : orow0 + RW'(1);
            end else begin
                out_col_next = ocol0 + CW'(1);
                out_row_next = orow0;
            end
        end else if (!s_func && in_row_reg == '0 && in_col_reg == '0) begin
            out_col_next = '0;
            out_row_next = '0;
        end
        eol0 = (ocol0 >= w_last_reg);
        eof0 = eol0 && (orow0 >= h_last_reg);
        // colour role from the pattern phase
        if (orow0[0] == pattern_reg[1] && ocol0[0] == pattern_reg[0]) begin
            site0 = bbd_pkg::SITE_RED;
        end else if (orow0[0] != pattern_reg[1] && ocol0[0] != pattern_reg[0]) begin
            site0 = bbd_pkg::SITE_BLUE;
        end else if (orow0[0] == pattern_reg[1]) begin
            site0 = bbd_pkg::SITE_GREEN_RROW;
        end else begin
            site0 = bbd_pkg::SITE_GREEN_BROW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else if (s_accept) begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // stage 1 registers
    bbd_pkg::res_kind_t s1_kind_reg;
    bbd_pkg::site_t     s1_site_reg;
    logic               s1_eol_reg, s1_eof_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic [PW-1:0]      s1_value_reg;
    logic               fwd_rd_reg, fwd_b_reg;
    logic [PW-1:0]      fwd_up_reg, fwd_mid_reg;
    logic [PW-1:0]      mid_eff, up_a_eff, up_b_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_rd_reg   <= 1'b0;
            fwd_b_reg    <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
            fwd_rd_reg   <= mem_we && (rd_addr == s1_addr_reg);
            fwd_b_reg    <= mem_we && (w_last_reg == s1_addr_reg);
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
            fwd_rd_reg   <= 1'b0;
            fwd_b_reg    <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg  <= kind0;
            s1_site_reg  <= site0;
            s1_pixel_reg <= !s_func;
            s1_eol_reg   <= eol0;
            s1_eof_reg   <= eof0;
            s1_addr_reg  <= rd_addr;
            s1_value_reg <= s_raw_pixel;
            fwd_up_reg   <= mid_eff;
            fwd_mid_reg  <= s1_value_reg;
        end
    end

    // line memories: upper holds the line two above, middle the line above
    logic [PW-1:0] upper_mem  [MAX_WIDTH];
    logic [PW-1:0] middle_mem [MAX_WIDTH];
    logic [PW-1:0] up_a_rd_reg, up_b_rd_reg, mid_rd_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            upper_mem[s1_addr_reg] <= mid_eff;
        end
        if (s_accept) begin
            up_a_rd_reg <= upper_mem[rd_addr];
            up_b_rd_reg <= upper_mem[w_last_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            middle_mem[s1_addr_reg] <= s1_value_reg;
        end
        if (s_accept) begin
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // forward a write-back that raced the read
    assign up_a_eff = fwd_rd_reg ? fwd_up_reg  : up_a_rd_reg;
    assign up_b_eff = fwd_b_reg  ? fwd_up_reg  : up_b_rd_reg;
    assign mid_eff  = fwd_rd_reg ? fwd_mid_reg : mid_rd_reg;

    // window: middle and right columns, top to bottom
    logic [PW-1:0] win_mid_reg   [3];
    logic [PW-1:0] win_right_reg [3];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mid_reg[0]   <= win_right_reg[0];
            win_mid_reg[1]   <= win_right_reg[1];
            win_mid_reg[2]   <= win_right_reg[2];
            win_right_reg[0] <= up_a_eff;
            win_right_reg[1] <= mid_eff;
            win_right_reg[2] <= s1_value_reg;
        end
    end

    // interpolation on the shifted window
    logic [PW-1:0] n0, n1, n2, n3, n4, n5, n6, n7, n8;
    logic [PW+1:0] corner_sum, edge_sum;
    logic [PW:0]   horiz_sum, vert_sum;
    logic [PW-1:0] corners, edges, horiz, vert;
    logic [PW-1:0] ip_blue, ip_green, ip_red, flat, res_blue, res_green, res_red;

    always_comb begin
        n0 = win_mid_reg[0];
        n1 = win_right_reg[0];
        n2 = up_a_eff;
        n3 = win_mid_reg[1];
        n4 = win_right_reg[1];
        n5 = mid_eff;
        n6 = win_mid_reg[2];
        n7 = win_right_reg[2];
        n8 = s1_value_reg;
        corner_sum = (PW+2)'(n0) + (PW+2)'(n2) + (PW+2)'(n6) + (PW+2)'(n8);
        edge_sum   = (PW+2)'(n1) + (PW+2)'(n3) + (PW+2)'(n5) + (PW+2)'(n7);
        horiz_sum  = (PW+1)'(n3) + (PW+1)'(n5);
        vert_sum   = (PW+1)'(n1) + (PW+1)'(n7);
        corners    = corner_sum[PW+1:2];
        edges      = edge_sum[PW+1:2];
        horiz      = horiz_sum[PW:1];
        vert       = vert_sum[PW:1];
        case (s1_site_reg)
            bbd_pkg::SITE_RED: begin
                ip_red = n4; ip_green = edges; ip_blue = corners;
            end
            bbd_pkg::SITE_BLUE: begin
                ip_blue = n4; ip_green = edges; ip_red = corners;
            end
            bbd_pkg::SITE_GREEN_RROW: begin
                ip_green = n4; ip_red = horiz; ip_blue = vert;
            end
            default: begin
                ip_green = n4; ip_blue = horiz; ip_red = vert;
            end
        endcase
        // border and tail pixels copy one raw sample
        case (s1_kind_reg)
            bbd_pkg::RES_TAIL:   flat = up_b_eff;
            bbd_pkg::RES_UPPER:  flat = up_a_eff;
            bbd_pkg::RES_MIDDLE: flat = mid_eff;
            default:             flat = n4;
        endcase
        if (s1_kind_reg == bbd_pkg::RES_INTERIOR) begin
            res_blue  = clip_px(ip_blue, max_value_reg);
            res_green = clip_px(ip_green, max_value_reg);
            res_red   = clip_px(ip_red, max_value_reg);
        end else begin
            res_blue  = flat;
            res_green = flat;
            res_red   = flat;
        end
    end

    // output register
    logic [PW-1:0] out_blue_reg, out_green_reg, out_red_reg;
    logic          out_eol_reg, out_eof_reg;
    logic          s1_emit;

    assign s1_emit = (s1_kind_reg != bbd_pkg::RES_NONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire && s1_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_emit) begin
            out_blue_reg  <= res_blue;
            out_green_reg <= res_green;
            out_red_reg   <= res_red;
            out_eol_reg   <= s1_eol_reg;
            out_eof_reg   <= s1_eof_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_blue         = out_blue_reg;
    assign m_green        = out_green_reg;
    assign m_red          = out_red_reg;
    assign m_end_of_line  = out_eol_reg;
    assign m_end_of_frame = out_eof_reg;

    // checks
    a_fwd_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (fwd_rd_reg || fwd_b_reg) |-> s1_valid_reg)
        else $error("forwarding flag set with stage 1 empty");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_func && in_row_reg == '0 && in_col_reg == '0)
        |=> (out_row_reg == '0 && out_col_reg == '0))
        else $error("frame start did not reset the output position");

    a_flat_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_emit && s1_kind_reg != bbd_pkg::RES_INTERIOR)
        |=> (m_blue == m_green && m_green == m_red))
        else $error("border pixel channels differ");

    a_eof_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_emit && s1_eof_reg) |=> (m_valid && m_end_of_line))
        else $error("end of frame without end of line");

endmodule
